[design/rps_pkg.sv]
// ----------------------------------------------------------------------------
// Roulette pair selection package
// Beat types, field widths and opcodes shared by the selection chain and its
// cells.
// ----------------------------------------------------------------------------
package rps_pkg;

  // Field widths of the beats and of the population count.
  localparam int FIT_W    = 32;
  localparam int SPIN_W   = 16;
  localparam int SLOT_W   = 6;
  localparam int PARENT_W = 6;
  localparam int CNT_W    = 7;

  // Two spins make one breeding pair.
  localparam int PAIR = 2;

  // Reset value of the population count register.
  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

  // Opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [SLOT_W-1:0] slot_index;
    logic [FIT_W-1:0]  fitness_value;
    logic [SPIN_W-1:0] first_fraction;
    logic [SPIN_W-1:0] second_fraction;
  } in_beat_t;

  typedef struct packed {
    logic [PARENT_W-1:0] first_parent;
    logic [PARENT_W-1:0] second_parent;
    logic                pair_kept;
  } out_beat_t;

  // Control part of the token that walks along the cell chain.
  typedef struct packed {
    logic            valid;
    logic            is_load;
    logic [PAIR-1:0] found;
  } rps_ctl_t;

endpackage

[design/roulette_pair_selection.sv]
// Path: an accepted draw beat passes the start register, the chain of POP_MAX cells, the hold
//   stage and the output register before it is offered on the output. Only one beat at a time
//   walks as a token once through the chain, and the input stalls until it is through; a load
//   to a slot beyond the store is taken and dropped. A new beat is taken while a finished
//   result waits on the output. Reset: all fitness slots and the fitness total clear to zero,
//   population count is 64, and the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// Roulette pair selection
// Fitness-proportional selection of breeding pairs over a chain of fitness
// cells, with loads that keep the fitness total up to date.
// ----------------------------------------------------------------------------
module roulette_pair_selection #(
  parameter int POP_MAX = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rps_pkg::CNT_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rps_pkg::in_beat_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rps_pkg::out_beat_t          out_data_o
);
  import rps_pkg::*;

  localparam int IDX_W   = $clog2(POP_MAX);
  localparam int TOTAL_W = FIT_W + IDX_W;
  localparam int TGT_W   = TOTAL_W + SPIN_W;

  // Configuration and kept state.
  logic [CNT_W-1:0]           cnt_q;
  logic [TOTAL_W-1:0]         total_q, total_d;

  // Control of the beat in flight. Only one token walks the chain at a time,
  // so the spin targets and the load slot and value are broadcast to all
  // cells from registers that hold still while the token moves.
  logic                       busy_q, busy_d;
  logic                       start_q;
  logic                       op_load_q;
  logic [PAIR-1:0][TGT_W-1:0] tgt_q;
  logic [IDX_W-1:0]           ld_slot_q;
  logic [FIT_W-1:0]           ld_val_q;

  logic                       in_acc;
  logic                       is_draw;
  logic                       slot_ok;
  logic                       launch;

  // Chain wiring: entry 0 feeds the first cell, entry POP_MAX leaves the last.
  rps_ctl_t                   chain_ctl  [POP_MAX+1];
  logic [TOTAL_W-1:0]         chain_cum  [POP_MAX+1];
  logic [PAIR-1:0][IDX_W-1:0] chain_pick [POP_MAX+1];
  logic [POP_MAX-1:0]         in_use;
  logic [POP_MAX-1:0]         tok_vld;

  rps_ctl_t                   end_ctl;
  logic                       end_load;
  logic                       end_draw;
  logic [IDX_W-1:0]           last_idx;
  logic [PAIR-1:0][IDX_W-1:0] sel;

  // Result hold stage and output register.
  logic                       fin_valid_q, fin_valid_d;
  out_beat_t                  fin_q;
  logic                       out_valid_q, out_valid_d;
  out_beat_t                  out_q;
  logic                       out_take;
  logic                       move;

  // ---------------------------------------------------------------------------
  // Input side. A load to a slot beyond the store is taken and dropped.
  // ---------------------------------------------------------------------------
  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;
  assign is_draw    = (in_data_i.opcode == OP_DRAW);
  assign slot_ok    = (32'(in_data_i.slot_index) < POP_MAX);
  assign launch     = in_acc && (is_draw || slot_ok);

  // Spin targets are fraction times total; the products are registered
  // before any cell compares against them.
  always_ff @(posedge clk_i) begin
    if (in_acc && is_draw) begin
      tgt_q[0] <= TGT_W'(in_data_i.first_fraction) * TGT_W'(total_q);
      tgt_q[1] <= TGT_W'(in_data_i.second_fraction) * TGT_W'(total_q);
    end
    if (in_acc && !is_draw) begin
      ld_slot_q <= IDX_W'(in_data_i.slot_index);
      ld_val_q  <= in_data_i.fitness_value;
    end
    if (launch) begin
      op_load_q <= !is_draw;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain. A cell is in use when its index is below the population
  // count; slot 0 is always in use so that a count of zero acts as one.
  // ---------------------------------------------------------------------------
  assign chain_ctl[0].valid   = start_q;
  assign chain_ctl[0].is_load = op_load_q;
  assign chain_ctl[0].found   = '0;
  assign chain_cum[0]         = '0;
  assign chain_pick[0]        = '0;

  for (genvar k = 0; k < POP_MAX; k++) begin : g_cell
    assign in_use[k]  = (k == 0) || (32'(cnt_q) > k);
    assign tok_vld[k] = chain_ctl[k+1].valid;

    rps_cell #(
      .TOTAL_W  (TOTAL_W),
      .IDX_W    (IDX_W),
      .TGT_W    (TGT_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .in_use_i  (in_use[k]),
      .ld_slot_i (ld_slot_q),
      .ld_val_i  (ld_val_q),
      .tgt_i     (tgt_q),
      .ctl_i     (chain_ctl[k]),
      .cum_i     (chain_cum[k]),
      .pick_i    (chain_pick[k]),
      .ctl_o     (chain_ctl[k+1]),
      .cum_o     (chain_cum[k+1]),
      .pick_o    (chain_pick[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Chain end. A load token returns the old value of its slot, which swaps
  // out of the total. A draw token returns its picks; a spin that found no
  // slot takes the last slot in use.
  // ---------------------------------------------------------------------------
  assign end_ctl  = chain_ctl[POP_MAX];
  assign end_load = end_ctl.valid && end_ctl.is_load;
  assign end_draw = end_ctl.valid && !end_ctl.is_load;

  always_comb begin
    if (cnt_q == '0) begin
      last_idx = '0;
    end else if (32'(cnt_q) > POP_MAX) begin
      last_idx = IDX_W'(POP_MAX - 1);
    end else begin
      last_idx = IDX_W'(cnt_q - CNT_W'(1));
    end
    for (int s = 0; s < PAIR; s++) begin
      sel[s] = end_ctl.found[s] ? chain_pick[POP_MAX][s] : last_idx;
    end
  end

  assign total_d = end_load ? (total_q - chain_cum[POP_MAX] + TOTAL_W'(ld_val_q)) : total_q;

  // ---------------------------------------------------------------------------
  // Output side. The hold stage catches a finished draw even while the output
  // register still waits for its beat to be taken.
  // ---------------------------------------------------------------------------
  assign out_take = out_valid_q && !out_stall_i;
  assign move     = fin_valid_q && (!out_valid_q || out_take);

  always_comb begin
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end

    fin_valid_d = fin_valid_q;
    if (end_draw) begin
      fin_valid_d = 1'b1;
    end else if (move) begin
      fin_valid_d = 1'b0;
    end

    busy_d = busy_q;
    if (launch) begin
      busy_d = 1'b1;
    end else if (end_load || move) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CNT_RESET;
      total_q     <= '0;
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
      total_q     <= total_d;
      busy_q      <= busy_d;
      start_q     <= launch;
      fin_valid_q <= fin_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_draw) begin
      fin_q.first_parent  <= PARENT_W'(sel[0]);
      fin_q.second_parent <= PARENT_W'(sel[1]);
      fin_q.pair_kept     <= (sel[0] != sel[1]);
    end
    if (move) begin
      out_q <= fin_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // At most one token is on its way through the chain.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({start_q, tok_vld}) <= 1)
    else $error("more than one token in the cell chain");

  // A result in the hold stage keeps the input side closed.
  a_fin_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q |-> busy_q)
    else $error("held result without busy");

  // A token leaving the chain belongs to the beat in flight and finds the
  // hold stage empty.
  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_ctl.valid |-> (busy_q && !fin_valid_q))
    else $error("token left the chain while idle or hold stage full");

endmodule

[design/rps_cell.sv]
// ----------------------------------------------------------------------------
// Roulette selection cell
// Holds one fitness slot, adds it to the running sum of a draw token or of a
// load token for it, and marks spins whose threshold the sum crosses here.
// ----------------------------------------------------------------------------
module rps_cell #(
  parameter int TOTAL_W  = 38,
  parameter int IDX_W    = 6,
  parameter int TGT_W    = 54,
  parameter int CELL_IDX = 0
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_use_i,
  input  logic [IDX_W-1:0]                         ld_slot_i,
  input  logic [rps_pkg::FIT_W-1:0]                ld_val_i,
  input  logic [rps_pkg::PAIR-1:0][TGT_W-1:0]      tgt_i,
  input  rps_pkg::rps_ctl_t                        ctl_i,
  input  logic [TOTAL_W-1:0]                       cum_i,
  input  logic [rps_pkg::PAIR-1:0][IDX_W-1:0]      pick_i,
  output rps_pkg::rps_ctl_t                        ctl_o,
  output logic [TOTAL_W-1:0]                       cum_o,
  output logic [rps_pkg::PAIR-1:0][IDX_W-1:0]      pick_o
);
  import rps_pkg::*;

  logic [FIT_W-1:0]             fit_q, fit_d;
  rps_ctl_t                     ctl_q, ctl_d;
  logic [TOTAL_W-1:0]           cum_q, cum_d;
  logic [PAIR-1:0][IDX_W-1:0]   pick_q, pick_d;
  logic                         match;
  logic [FIT_W-1:0]             add_val;
  logic [TGT_W-1:0]             scaled;
  logic [PAIR-1:0]              hit;

  assign match = (ld_slot_i == IDX_W'(CELL_IDX));

  // A load token only gathers the old value of the slot it rewrites.
  assign add_val = (ctl_i.is_load && !match) ? '0 : fit_q;
  assign cum_d   = cum_i + TOTAL_W'(add_val);
  assign scaled  = {cum_d, {SPIN_W{1'b0}}};

  always_comb begin
    fit_d = fit_q;
    if (ctl_i.valid && ctl_i.is_load && match) begin
      fit_d = ld_val_i;
    end
    ctl_d.valid   = ctl_i.valid;
    ctl_d.is_load = ctl_i.is_load;
    for (int s = 0; s < PAIR; s++) begin
      hit[s]       = ctl_i.valid && !ctl_i.is_load && in_use_i && (scaled > tgt_i[s]);
      ctl_d.found[s] = ctl_i.found[s] | hit[s];
      pick_d[s]    = (!ctl_i.found[s] && hit[s]) ? IDX_W'(CELL_IDX) : pick_i[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q <= '0;
      ctl_q <= '0;
    end else begin
      fit_q <= fit_d;
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cum_q  <= cum_d;
    pick_q <= pick_d;
  end

  assign ctl_o  = ctl_q;
  assign cum_o  = cum_q;
  assign pick_o = pick_q;

  // A load token never marks a spin as found.
  a_load_no_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.valid && ctl_q.is_load) |-> (ctl_q.found == '0))
    else $error("load token carries a found flag");

  // Once a spin has found its slot the flag stays set down the chain.
  a_found_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.valid |=> ((ctl_q.found & $past(ctl_i.found)) == $past(ctl_i.found)))
    else $error("found flag dropped in cell");

endmodule

[verif/roulette_pair_selection_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Roulette pair selection testbench
// Loads fitness values and draws breeding pairs under random sender bursts and
// receiver stalls, checks each pair against a typed or cycle-free predicted one.
// ----------------------------------------------------------------------------
module roulette_pair_selection_tb;
  import rps_pkg::*;

  localparam int POP_MAX = 64;
  // Generous bound on the whole run, in clock cycles.
  localparam int unsigned CYCLE_LIMIT = 800000;
  // Cycles to let a load finish its walk through the cell chain before the
  // population count may be changed, or before the run ends.
  localparam int DRAIN_CYCLES = POP_MAX + 10;

  // A directed row is either one input beat or one write of the population
  // count register.
  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic                op;
    logic [SLOT_W-1:0]   slot;
    logic [FIT_W-1:0]    fit;
    logic [SPIN_W-1:0]   spin_a;
    logic [SPIN_W-1:0]   spin_b;
    logic [CNT_W-1:0]    cfg_val;
    bit                  typed;
    logic [PARENT_W-1:0] want_a;
    logic [PARENT_W-1:0] want_b;
    logic                want_kept;
  } row_t;

  // Block ports. Every input has a known value from time zero.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CNT_W-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_beat_t           in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_beat_t          out_data_o;

  // Predictor state: the fitness slots, their total and the population count.
  logic [FIT_W-1:0]   fit_store [POP_MAX] = '{default: '0};
  logic [37:0]        fit_total = '0;
  logic [CNT_W-1:0]   pop_count = CNT_RESET;

  // Pairs that accepted draw beats will produce, oldest first.
  out_beat_t          pending_pairs [$];
  out_beat_t          want_pair;

  int unsigned        err_cnt    = 0;
  int unsigned        cycle_cnt  = 0;
  int unsigned        burst_left = 0;
  int unsigned        gap_len    = 0;
  int unsigned        stall_mode = 0;
  int unsigned        stall_run  = 0;

  roulette_pair_selection #(
    .POP_MAX(POP_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // A count of zero still uses one slot, and anything above the store size is
  // clamped to the store size.
  function automatic int unsigned slots_used();
    if (pop_count == '0) return 1;
    if (pop_count > POP_MAX) return POP_MAX;
    return pop_count;
  endfunction

  // Spin the wheel twice. Each spin picks the first slot in use whose running
  // fitness sum, scaled by 2^SPIN_W, is strictly above spin times the total.
  // A spin that lands on no slot falls to the last slot in use, which also
  // covers an all-zero total and fitness parked in slots beyond the count.
  function automatic out_beat_t spin_wheel(input logic [SPIN_W-1:0] spin_a,
                                           input logic [SPIN_W-1:0] spin_b);
    int unsigned         used;
    int unsigned         k;
    logic [63:0]         aim_a, aim_b, running, scaled;
    logic [PARENT_W-1:0] pick_a, pick_b;
    bit                  hit_a, hit_b;
    out_beat_t           pair;
    used    = slots_used();
    aim_a   = 64'(spin_a) * 64'(fit_total);
    aim_b   = 64'(spin_b) * 64'(fit_total);
    pick_a  = PARENT_W'(used - 1);
    pick_b  = PARENT_W'(used - 1);
    hit_a   = 1'b0;
    hit_b   = 1'b0;
    running = '0;
    for (k = 0; k < used; k++) begin
      running += 64'(fit_store[k]);
      scaled   = running << SPIN_W;
      if (!hit_a && scaled > aim_a) begin
        hit_a  = 1'b1;
        pick_a = PARENT_W'(k);
      end
      if (!hit_b && scaled > aim_b) begin
        hit_b  = 1'b1;
        pick_b = PARENT_W'(k);
      end
    end
    pair.first_parent  = pick_a;
    pair.second_parent = pick_b;
    pair.pair_kept     = (pick_a != pick_b);
    return pair;
  endfunction

  // Spins lean on both ends of the range now and then.
  function automatic logic [SPIN_W-1:0] pick_spin();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return SPIN_W'($urandom());
    endcase
  endfunction

  task automatic note_fail(input string what, input out_beat_t want, input out_beat_t got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("[%0t] %s: expected %0d/%0d/%0d, got %0d/%0d/%0d", $realtime, what,
               want.first_parent, want.second_parent, want.pair_kept,
               got.first_parent, got.second_parent, got.pair_kept);
    end
  endtask

  // Offer one beat and hold it until the block takes it. The sender works in
  // bursts: when a burst runs out, valid drops for a gap before the next beat,
  // so valid is never lowered and raised within the same step. Once the beat
  // is taken, the predictor either updates its store (load) or queues the
  // pair that the draw must produce.
  task automatic send_beat(input in_beat_t beat, input bit use_typed,
                           input out_beat_t typed_pair);
    out_beat_t queued;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 4);
      repeat (gap_len) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    if (beat.opcode == OP_DRAW) begin
      queued = use_typed ? typed_pair
               : spin_wheel(beat.first_fraction, beat.second_fraction);
      pending_pairs = {pending_pairs, queued};
    end else begin
      fit_total = fit_total - 38'(fit_store[beat.slot_index]) + 38'(beat.fitness_value);
      fit_store[beat.slot_index] = beat.fitness_value;
    end
  endtask

  // The count register is only written while the block is idle: every pair
  // has come out and any load still walking the chain has had time to finish.
  task automatic write_count(input logic [CNT_W-1:0] value);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pop_count = value;
  endtask

  // The receiver stalls on its own schedule: stretches with no stalls,
  // stretches of coin-flip stalls, long heavy stalls and rare single stalls.
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(20, 300);
    end else begin
      stall_run  <= stall_run - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 1) == 1);
      2:       out_stall_i <= ($urandom_range(0, 7) != 0);
      default: out_stall_i <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Every output beat taken is compared field by field with the oldest pair
  // waiting. Outputs are read just after the edge, so they hold the values
  // that the edge itself saw.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pairs.size() == 0) begin
        note_fail("pair with none expected", '0, out_data_o);
      end else begin
        want_pair = pending_pairs.pop_front();
        if (want_pair.first_parent  !== out_data_o.first_parent  ||
            want_pair.second_parent !== out_data_o.second_parent ||
            want_pair.pair_kept     !== out_data_o.pair_kept) begin
          note_fail("pair mismatch", want_pair, out_data_o);
        end
      end
    end
  end

  // A hung handshake or a lost pair ends here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    row_t             dir_rows [0:24];
    logic [CNT_W-1:0] phase_counts [0:7];
    in_beat_t         beat;
    int unsigned      ph;

    // Directed rows. Pairs are typed in only where they follow at once from
    // the store contents; the rest go through the predictor. With slot 0 and
    // slot 63 both at full scale, spins just below and at one half land on
    // either side of the first slot's edge.
    dir_rows = '{
      // Empty store after reset: no slot qualifies, both spins fall to slot 63.
      '{ROW_BEAT, OP_DRAW, 6'd0,  32'h0000_0000, 16'h0000, 16'hFFFF, 7'd0, 1'b1,
        6'd63, 6'd63, 1'b0},
      // A count of zero acts as one slot, so every pick is slot 0.
      '{ROW_CFG,  OP_LOAD, 6'd0,  32'h0000_0000, 16'h0000, 16'h0000, 7'd0, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_DRAW, 6'd0,  32'h0000_0000, 16'h1234, 16'hABCD, 7'd0, 1'b1,
        6'd0, 6'd0, 1'b0},
      // A count above the store size acts as the full store.
      '{ROW_CFG,  OP_LOAD, 6'd0,  32'h0000_0000, 16'h0000, 16'h0000, 7'd127, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_LOAD, 6'd0,  32'hFFFF_FFFF, 16'h0000, 16'h0000, 7'd0, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_DRAW, 6'd0,  32'h0000_0000, 16'h0000, 16'hFFFF, 7'd0, 1'b1,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_LOAD, 6'd63, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 7'd0, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_DRAW, 6'd0,  32'h0000_0000, 16'h7FFF, 16'h8000, 7'd0, 1'b1,
        6'd0, 6'd63, 1'b1},
      '{ROW_BEAT, OP_DRAW, 6'd0,  32'h0000_0000, 16'hFFFF, 16'h0000, 7'd0, 1'b1,
        6'd63, 6'd0, 1'b1},
      // Fitness in slot 63 lies beyond two slots in use, so a high spin
      // falls to the last slot in use.
      '{ROW_CFG,  OP_LOAD, 6'd0,  32'h0000_0000, 16'h0000, 16'h0000, 7'd2, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_DRAW, 6'd0,  32'h0000_0000, 16'h0000, 16'hFFFF, 7'd0, 1'b1,
        6'd0, 6'd1, 1'b1},
      '{ROW_CFG,  OP_LOAD, 6'd0,  32'h0000_0000, 16'h0000, 16'h0000, 7'd64, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_LOAD, 6'd0,  32'h0000_0000, 16'h0000, 16'h0000, 7'd0, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_LOAD, 6'd63, 32'h0000_0000, 16'h0000, 16'h0000, 7'd0, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_LOAD, 6'd5,  32'h0000_0001, 16'h0000, 16'h0000, 7'd0, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_LOAD, 6'd6,  32'h0000_0001, 16'h0000, 16'h0000, 7'd0, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_DRAW, 6'd0,  32'h0000_0000, 16'h0000, 16'hFFFF, 7'd0, 1'b0,
        6'd0, 6'd0, 1'b0},
      // Equal spins pick the same slot, so the pair is rejected.
      '{ROW_BEAT, OP_DRAW, 6'd0,  32'h0000_0000, 16'h8000, 16'h8000, 7'd0, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_LOAD, 6'd42, 32'hA5A5_A5A5, 16'h0000, 16'h0000, 7'd0, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_LOAD, 6'd21, 32'h5A5A_5A5A, 16'h0000, 16'h0000, 7'd0, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_DRAW, 6'd0,  32'h0000_0000, 16'h3C3C, 16'hC3C3, 7'd0, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_CFG,  OP_LOAD, 6'd0,  32'h0000_0000, 16'h0000, 16'h0000, 7'd1, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_DRAW, 6'd0,  32'h0000_0000, 16'hFFFF, 16'h0001, 7'd0, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_CFG,  OP_LOAD, 6'd0,  32'h0000_0000, 16'h0000, 16'h0000, 7'd63, 1'b0,
        6'd0, 6'd0, 1'b0},
      '{ROW_BEAT, OP_DRAW, 6'd0,  32'h0000_0000, 16'h9999, 16'h6666, 7'd0, 1'b0,
        6'd0, 6'd0, 1'b0}
    };

    // Population counts of the random phases, both ends and beyond included.
    phase_counts = '{7'd64, 7'd2, 7'd0, 7'd37, 7'd127, 7'd1, 7'd63, 7'd0};
    phase_counts[3] = CNT_W'($urandom_range(3, 62));
    phase_counts[7] = CNT_W'($urandom_range(0, 127));

    // Reset is held low from time zero and released on a clock edge.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        write_count(dir_rows[r].cfg_val);
      end else begin
        beat = '{opcode: dir_rows[r].op, slot_index: dir_rows[r].slot,
                 fitness_value: dir_rows[r].fit, first_fraction: dir_rows[r].spin_a,
                 second_fraction: dir_rows[r].spin_b};
        send_beat(beat, dir_rows[r].typed,
                  '{first_parent: dir_rows[r].want_a, second_parent: dir_rows[r].want_b,
                    pair_kept: dir_rows[r].want_kept});
      end
    end

    // Random phases. Loads mostly fill slots in use so that the wheel has
    // real shape; fitness magnitudes range from zero through small counts
    // to full scale, so that spins land on every part of the wheel.
    for (ph = 0; ph < 8; ph++) begin
      write_count(phase_counts[ph]);
      repeat (88) begin
        beat.opcode     = ($urandom_range(0, 99) < 45) ? OP_LOAD : OP_DRAW;
        beat.slot_index = ($urandom_range(0, 4) != 0) ?
                          SLOT_W'($urandom_range(0, slots_used() - 1)) : SLOT_W'($urandom());
        case ($urandom_range(0, 6))
          0:       beat.fitness_value = '0;
          1, 2:    beat.fitness_value = FIT_W'($urandom_range(0, 15));
          3, 4:    beat.fitness_value = $urandom();
          5:       beat.fitness_value = {16'hFFFF, 16'($urandom())};
          default: beat.fitness_value = $urandom() >> $urandom_range(0, 31);
        endcase
        beat.first_fraction  = pick_spin();
        beat.second_fraction = pick_spin();
        send_beat(beat, 1'b0, '0);
      end
    end

    // Wait out every pair, then give a trailing load time to finish, so that
    // a stray beat would still be caught before the verdict.
    in_valid_i <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
